// ===== src/dnt_pkg.sv =====
// Package for the directory name table: field widths, parameter defaults,
// request and status codes. No dependencies.
`default_nettype none

package dnt_pkg;

  // Parameter defaults
  localparam int unsigned DEF_ENTRIES     = 64;
  localparam int unsigned DEF_NAME_BYTES  = 8;
  localparam int unsigned DEF_SECTOR_BITS = 10;

  // Fixed field widths of the request and response transactions
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SECT_W   = 10;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STATUS_W = 2;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request codes
  localparam action_t ACT_LOOKUP  = 3'd0;
  localparam action_t ACT_ADD     = 3'd1;
  localparam action_t ACT_RM_NAME = 3'd2;
  localparam action_t ACT_READ    = 3'd3;
  localparam action_t ACT_RM_IDX  = 3'd4;

  // Status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_DUPLICATE = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

endpackage : dnt_pkg

`default_nettype wire

// ===== src/dnt_req_if.sv =====
// Request channel of the directory name table: valid/ready plus payload.
// Depends on dnt_pkg for the field widths.
`default_nettype none

interface dnt_req_if;
  logic                              valid;
  logic                              ready;
  dnt_pkg::action_t                  action;
  logic [dnt_pkg::KEY_W-1:0]         name_key;
  logic [dnt_pkg::SECT_W-1:0]        sector_in;
  logic                              type_in;
  logic [dnt_pkg::SLOT_W-1:0]        slot_in;

  modport source (output valid, action, name_key, sector_in, type_in, slot_in,
                  input ready);
  modport sink   (input valid, action, name_key, sector_in, type_in, slot_in,
                  output ready);
endinterface : dnt_req_if

`default_nettype wire

// ===== src/dnt_rsp_if.sv =====
// Response channel of the directory name table: valid/ready plus payload.
// Depends on dnt_pkg for the field widths.
`default_nettype none

interface dnt_rsp_if;
  logic                              valid;
  logic                              ready;
  dnt_pkg::status_t                  status;
  logic [dnt_pkg::SLOT_W-1:0]        slot_out;
  logic [dnt_pkg::SECT_W-1:0]        sector_out;
  logic                              is_dir;
  logic [dnt_pkg::KEY_W-1:0]         name_out;

  modport source (output valid, status, slot_out, sector_out, is_dir, name_out,
                  input ready);
  modport sink   (input valid, status, slot_out, sector_out, is_dir, name_out,
                  output ready);
endinterface : dnt_rsp_if

`default_nettype wire

// ===== src/directory_name_table_unit.sv =====
// Directory name table: entry memory, sequential scan engine and response register.
// Depends on dnt_pkg, dnt_req_if and dnt_rsp_if.
//
// The table holds ENTRIES directory entries (valid, name, header sector, type) in one
// synchronous single-port-write memory with a registered read. After reset a clearing
// pass writes every entry invalid, one entry a cycle; no request is taken during it.
// Name-based requests (lookup, add, remove by name) scan the memory from entry 0 upward,
// one read a cycle, and stop at the first valid entry whose normalized name matches; an
// add that finds no duplicate scans the whole table, tracking the lowest free entry, then
// writes it. The time a name request takes is therefore bounded by the single memory
// read port. Read by index reads only the requested entry; remove by index and unknown
// codes skip the scan. Names are normalized before use: only the first NAME_BYTES bytes
// count and the first zero byte ends the name. One transaction is in flight at a time; a
// new request is accepted while the previous response still waits in the output
// register, and its result is held back until that register is free.
`default_nettype none

module directory_name_table_unit #(
  parameter int unsigned ENTRIES     = dnt_pkg::DEF_ENTRIES,
  parameter int unsigned NAME_BYTES  = dnt_pkg::DEF_NAME_BYTES,
  parameter int unsigned SECTOR_BITS = dnt_pkg::DEF_SECTOR_BITS
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  dnt_req_if.sink    req_i,
  dnt_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned NAME_W = 8 * NAME_BYTES;
  localparam int unsigned SLOT_W = dnt_pkg::SLOT_W;
  localparam int unsigned SECT_W = dnt_pkg::SECT_W;
  localparam int unsigned KEY_W  = dnt_pkg::KEY_W;

  localparam logic [IDX_W-1:0]        LAST_IDX    = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W+SLOT_W-1:0] ENTRIES_EXT = (IDX_W + SLOT_W)'(ENTRIES);

  typedef struct packed {
    logic                   valid;
    logic                   is_dir;
    logic [SECTOR_BITS-1:0] sector;
    logic [NAME_W-1:0]      name;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Keep bytes up to the first zero byte, within the first NAME_BYTES bytes.
  function automatic logic [NAME_W-1:0] norm_name(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] res;
    logic             live;
    res  = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b < NAME_BYTES) begin
        live = live && (key[8*b +: 8] != 8'h00);
        if (live) begin
          res[8*b +: 8] = key[8*b +: 8];
        end
      end
    end
    return res[NAME_W-1:0];
  endfunction

  // Entry memory
  entry_t           entry_mem [ENTRIES];
  entry_t           rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // Control and request context
  state_e                 state_q;
  logic [IDX_W-1:0]       addr_q;
  logic                   issued_all_q;
  logic                   rd_pend_q;
  logic                   rd_last_q;
  logic [IDX_W-1:0]       ridx_q;
  dnt_pkg::action_t       action_q;
  logic [NAME_W-1:0]      name_q;
  logic [SECTOR_BITS-1:0] sector_q;
  logic                   type_q;
  logic [IDX_W-1:0]       slot_idx_q;
  logic [SLOT_W-1:0]      slot_raw_q;
  logic                   in_range_q;
  logic                   by_index_q;

  // Scan results
  logic             hit_q;
  logic [IDX_W-1:0] hit_idx_q;
  entry_t           hit_entry_q;
  logic             free_q;
  logic [IDX_W-1:0] free_idx_q;

  // Response register
  logic                   out_valid_q;
  dnt_pkg::status_t       out_status_q;
  logic [SLOT_W-1:0]      out_slot_q;
  logic [SECT_W-1:0]      out_sector_q;
  logic                   out_dir_q;
  logic [KEY_W-1:0]       out_name_q;

  // Decoded request fields
  logic [IDX_W+SLOT_W-1:0]      slot_ext;
  logic [SECTOR_BITS+SECT_W-1:0] sect_in_ext;
  logic                          in_range;
  logic                          req_fire;
  logic                          out_free;
  logic                          match_c;
  logic                          scan_end;
  logic                          is_name_op;

  // Result fields assembled in S_DONE
  dnt_pkg::status_t  res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [SLOT_W-1:0] res_slot;
  logic [SECTOR_BITS-1:0] res_sector;
  logic              res_dir;
  logic [NAME_W-1:0] res_name;
  logic              res_has_entry;
  logic [IDX_W+SLOT_W-1:0]       res_idx_ext;
  logic [SECTOR_BITS+SECT_W-1:0] res_sect_ext;
  logic [NAME_W+KEY_W-1:0]       res_name_ext;

  assign slot_ext    = {{IDX_W{1'b0}}, req_i.slot_in};
  assign sect_in_ext = {{SECTOR_BITS{1'b0}}, req_i.sector_in};
  assign in_range    = (slot_ext < ENTRIES_EXT);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign is_name_op  = (req_i.action == dnt_pkg::ACT_LOOKUP) ||
                       (req_i.action == dnt_pkg::ACT_ADD) ||
                       (req_i.action == dnt_pkg::ACT_RM_NAME);

  // A read by index matches any valid entry; a name scan needs the name too.
  assign match_c = rdata_q.valid && (by_index_q || (rdata_q.name == name_q));

  // The scan ends on the first match or after the last entry has been checked.
  assign scan_end = rd_pend_q && (match_c || rd_last_q);

  assign req_i.ready = (state_q == S_IDLE);

  // Result selection and write-back for the finishing request
  always_comb begin
    res_status    = dnt_pkg::ST_NOT_FOUND;
    res_idx       = hit_idx_q;
    res_sector    = hit_entry_q.sector;
    res_dir       = hit_entry_q.is_dir;
    res_name      = '0;
    res_has_entry = 1'b0;
    res_slot      = '0;
    mem_we        = 1'b0;
    mem_waddr     = addr_q;
    mem_wdata     = '0;

    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
    end

    unique case (action_q)
      dnt_pkg::ACT_LOOKUP: begin
        if (hit_q) begin
          res_status    = dnt_pkg::ST_OK;
          res_has_entry = 1'b1;
        end
      end
      dnt_pkg::ACT_ADD: begin
        if (hit_q) begin
          res_status    = dnt_pkg::ST_DUPLICATE;
          res_has_entry = 1'b1;
        end else if (free_q) begin
          res_status    = dnt_pkg::ST_OK;
          res_has_entry = 1'b1;
          res_idx       = free_idx_q;
          res_sector    = sector_q;
          res_dir       = type_q;
          if (state_q == S_DONE && out_free) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx_q;
            mem_wdata = '{valid: 1'b1, is_dir: type_q, sector: sector_q, name: name_q};
          end
        end else begin
          res_status = dnt_pkg::ST_FULL;
        end
      end
      dnt_pkg::ACT_RM_NAME: begin
        if (hit_q) begin
          res_status    = dnt_pkg::ST_OK;
          res_has_entry = 1'b1;
          if (state_q == S_DONE && out_free) begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx_q;
          end
        end
      end
      dnt_pkg::ACT_READ: begin
        if (hit_q) begin
          res_status    = dnt_pkg::ST_OK;
          res_has_entry = 1'b1;
          res_name      = hit_entry_q.name;
        end
      end
      dnt_pkg::ACT_RM_IDX: begin
        if (in_range_q) begin
          res_status = dnt_pkg::ST_OK;
          if (state_q == S_DONE && out_free) begin
            mem_we    = 1'b1;
            mem_waddr = slot_idx_q;
          end
        end
      end
      default: begin
        res_status = dnt_pkg::ST_NOT_FOUND;
      end
    endcase

    res_idx_ext  = {{SLOT_W{1'b0}}, res_idx};
    res_sect_ext = {{SECT_W{1'b0}}, res_sector};
    res_name_ext = {{KEY_W{1'b0}}, res_name};
    if (res_has_entry) begin
      res_slot = res_idx_ext[SLOT_W-1:0];
    end else if (action_q == dnt_pkg::ACT_RM_IDX && in_range_q) begin
      res_slot = slot_raw_q;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= entry_mem[addr_q];
  end

  // Sequencer, scan tracking and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      addr_q       <= '0;
      issued_all_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      rd_last_q    <= 1'b0;
      ridx_q       <= '0;
      action_q     <= dnt_pkg::ACT_LOOKUP;
      name_q       <= '0;
      sector_q     <= '0;
      type_q       <= 1'b0;
      slot_idx_q   <= '0;
      slot_raw_q   <= '0;
      in_range_q   <= 1'b0;
      by_index_q   <= 1'b0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_entry_q  <= '0;
      free_q       <= 1'b0;
      free_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= dnt_pkg::ST_OK;
      out_slot_q   <= '0;
      out_sector_q <= '0;
      out_dir_q    <= 1'b0;
      out_name_q   <= '0;
    end else begin
      // Raise the response when the finishing request loads it; drop it once taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          // Invalidate one entry a cycle
          if (addr_q == LAST_IDX) begin
            addr_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end

        S_IDLE: begin
          if (req_fire) begin
            action_q     <= req_i.action;
            name_q       <= norm_name(req_i.name_key);
            sector_q     <= sect_in_ext[SECTOR_BITS-1:0];
            type_q       <= req_i.type_in;
            slot_idx_q   <= slot_ext[IDX_W-1:0];
            slot_raw_q   <= req_i.slot_in;
            in_range_q   <= in_range;
            hit_q        <= 1'b0;
            free_q       <= 1'b0;
            rd_pend_q    <= 1'b0;
            issued_all_q <= 1'b0;
            if (is_name_op) begin
              // Scan the table from entry 0, up to the first match
              by_index_q <= 1'b0;
              addr_q     <= '0;
              state_q    <= S_SCAN;
            end else if (req_i.action == dnt_pkg::ACT_READ && in_range) begin
              // One-entry scan at the requested index
              by_index_q <= 1'b1;
              addr_q     <= slot_ext[IDX_W-1:0];
              state_q    <= S_SCAN;
            end else begin
              state_q <= S_DONE;
            end
          end
        end

        S_SCAN: begin
          // Issue the next read; hold no read pending once the scan ends
          rd_pend_q <= !issued_all_q && !scan_end;
          if (!issued_all_q) begin
            ridx_q    <= addr_q;
            rd_last_q <= by_index_q || (addr_q == LAST_IDX);
            if (by_index_q || (addr_q == LAST_IDX)) begin
              issued_all_q <= 1'b1;
            end else begin
              addr_q <= addr_q + 1'b1;
            end
          end
          // Check the entry read in the previous cycle
          if (rd_pend_q) begin
            if (!rdata_q.valid && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= ridx_q;
            end
            if (match_c) begin
              hit_q       <= 1'b1;
              hit_idx_q   <= ridx_q;
              hit_entry_q <= rdata_q;
              state_q     <= S_DONE;
            end else if (rd_last_q) begin
              state_q <= S_DONE;
            end
          end
        end

        S_DONE: begin
          // Hold until the response register is free, then load it
          if (out_free) begin
            out_status_q <= res_status;
            out_slot_q   <= res_slot;
            out_sector_q <= res_has_entry ? res_sect_ext[SECT_W-1:0] : '0;
            out_dir_q    <= res_has_entry ? res_dir : 1'b0;
            out_name_q   <= res_name_ext[KEY_W-1:0];
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.slot_out   = out_slot_q;
  assign rsp_o.sector_out = out_sector_q;
  assign rsp_o.is_dir     = out_dir_q;
  assign rsp_o.name_out   = out_name_q;

endmodule : directory_name_table_unit

`default_nettype wire
